/* src/open_addressing_hash_table_assert.svh */
// assertion macros used by the hash table checker
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define OAHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define OAHT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/oaht_pkg.sv */
// shared types and constants of the open-addressed hash table
package oaht_pkg;

    // width of the table size register and of all probe arithmetic
    localparam int SZ_W       = 11;
    localparam int METHOD_W   = 2;
    localparam int FUNC_W     = 2;
    localparam int ST_W       = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // slot status codes
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd0;
    localparam logic [ST_W-1:0] ST_USED    = 2'd1;
    localparam logic [ST_W-1:0] ST_DELETED = 2'd2;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // probe methods, any other code probes as linear
    localparam logic [METHOD_W-1:0] METHOD_LINEAR = 2'd0;
    localparam logic [METHOD_W-1:0] METHOD_QUAD   = 2'd1;
    localparam logic [METHOD_W-1:0] METHOD_DOUBLE = 2'd2;

    // register indexes, taken from paddr[2]
    localparam logic REG_PROBE_METHOD = 1'b0;
    localparam logic REG_TABLE_SIZE   = 1'b1;

    localparam logic [SZ_W-1:0] SIZE_RESET = 11'd1024;

    // quadratic term 183*i + 8192*i*i: first difference 8375, second 16384
    localparam int              QUAD_STEP_W = 14;
    localparam logic [13:0]     QUAD_STEP   = 14'd8375;
    localparam int              QUAD_INC_W  = 15;
    localparam logic [14:0]     QUAD_INC    = 15'd16384;
    localparam int              CONST_IDX_W = 4;

    // control from the sequencer to the slot store
    typedef struct packed {
        logic            rd;
        logic            st_we;
        logic            key_we;
        logic [ST_W-1:0] st_data;
    } store_ctl_t;

endpackage

/* src/open_addressing_hash_table.sv */
// top level of the open-addressed hash table: sequencer, probe datapath, registers
//
// Requests (func, key) arrive on req_valid/req_stall and are taken at an edge with
// req_valid high and req_stall low. Each request gives one response on
// rsp_valid/rsp_stall: slot_index and failed, with slot_index zero on failure.
// Two APB registers at byte addresses 0 and 4: probe_method and table_size, to be
// written only while no request is in flight; the block does not enforce this.
// From the accepting edge to rsp_valid, a request runs through the one modular
// adder and the store read: the key is reduced, the quadratic constants are
// formed unless the method is linear, each probed slot takes address, read and
// check, and an advance comes between slots (linear, quadratic, or double form,
// whose i*h2 product runs through the adder); last the response is posted.
// A request with size zero or an unknown code goes straight to its response.
// One request at a time: req_stall stays high until the response is posted.
// After reset the block sweeps the status memory to empty, with req_stall high;
// APB writes are taken meanwhile.
// A stalled response holds in its register; a new request is taken while it
// waits, and its own response waits for the old one to leave.
module open_addressing_hash_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [oaht_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [oaht_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [oaht_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [oaht_pkg::FUNC_W-1:0]         func,
    input  logic [KEY_WIDTH-1:0]                key,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [$clog2(TABLE_DEPTH)-1:0]      slot_index,
    output logic                                failed
);

    localparam int IW      = $clog2(TABLE_DEPTH);
    localparam int SZ_W    = oaht_pkg::SZ_W;
    localparam int CNT_MAX = (KEY_WIDTH > 2 * SZ_W) ? KEY_WIDTH : 2 * SZ_W;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int BIT_W   = $clog2(SZ_W);

    // sequencer states
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_KMOD    = 4'd2;
    localparam logic [3:0] S_CONST1  = 4'd3;
    localparam logic [3:0] S_CONST2  = 4'd4;
    localparam logic [3:0] S_ADDR    = 4'd5;
    localparam logic [3:0] S_READ    = 4'd6;
    localparam logic [3:0] S_CHECK   = 4'd7;
    localparam logic [3:0] S_ADV_LIN = 4'd8;
    localparam logic [3:0] S_ADV_Q   = 4'd9;
    localparam logic [3:0] S_ADV_D   = 4'd10;
    localparam logic [3:0] S_MUL     = 4'd11;
    localparam logic [3:0] S_FINISH  = 4'd12;

    // control registers
    logic [3:0]                      state_reg, state_next;
    logic [IW-1:0]                   clr_reg, clr_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [oaht_pkg::METHOD_W-1:0]   probe_method_reg;
    logic [SZ_W-1:0]                 table_size_reg;

    // datapath registers
    logic [oaht_pkg::FUNC_W-1:0]     func_reg, func_next;
    logic [KEY_WIDTH-1:0]            key_reg, key_next;
    logic [oaht_pkg::METHOD_W-1:0]   m_reg, m_next;
    logic [SZ_W-1:0]                 s_reg, s_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [SZ_W-1:0]                 r_reg, r_next;
    logic [SZ_W-1:0]                 lin_reg, lin_next;
    logic [SZ_W-1:0]                 q_reg, q_next;
    logic [SZ_W-1:0]                 d_reg, d_next;
    logic [SZ_W-1:0]                 c2_reg, c2_next;
    logic [SZ_W-1:0]                 acc_reg, acc_next;
    logic [SZ_W-1:0]                 i_reg, i_next;
    logic [SZ_W-1:0]                 pos_reg, pos_next;
    logic                            ok_reg, ok_next;
    logic [IW-1:0]                   slot_index_reg, slot_index_next;
    logic                            failed_reg, failed_next;

    // shared adder and store
    logic [SZ_W-1:0]                 ua, ub, uy;
    logic                            ucin;
    oaht_pkg::store_ctl_t            ctl;
    logic [IW-1:0]                   store_addr;
    logic [oaht_pkg::ST_W-1:0]       rd_status;
    logic [KEY_WIDTH-1:0]            rd_key;

    logic                            cfg_we;
    logic [SZ_W-1:0]                 size_clamped;
    logic                            is_quad, is_dbl;
    logic [oaht_pkg::CONST_IDX_W-1:0] step_idx, inc_idx;
    logic [BIT_W-1:0]                mul_idx;
    logic                            key_match;

    oaht_modadd u_modadd (
        .a    (ua),
        .b    (ub),
        .cin  (ucin),
        .size (s_reg),
        .y    (uy)
    );

    oaht_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_store (
        .clk       (clk),
        .ctl       (ctl),
        .addr      (store_addr),
        .wkey      (key_reg),
        .rd_status (rd_status),
        .rd_key    (rd_key)
    );

    // apb register port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[2])
            oaht_pkg::REG_PROBE_METHOD: prdata = oaht_pkg::APB_DATA_W'(probe_method_reg);
            oaht_pkg::REG_TABLE_SIZE:   prdata = oaht_pkg::APB_DATA_W'(table_size_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_method_reg <= oaht_pkg::METHOD_LINEAR;
            table_size_reg   <= oaht_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == oaht_pkg::REG_PROBE_METHOD)
            begin
                probe_method_reg <= pwdata[oaht_pkg::METHOD_W-1:0];
            end
            else
            begin
                table_size_reg <= pwdata[SZ_W-1:0];
            end
        end
    end

    // size clamped to the depth of the store
    assign size_clamped = ({21'd0, table_size_reg} > 32'(TABLE_DEPTH)) ?
                          SZ_W'(TABLE_DEPTH) : table_size_reg;

    assign is_quad   = (m_reg == oaht_pkg::METHOD_QUAD);
    assign is_dbl    = (m_reg == oaht_pkg::METHOD_DOUBLE);
    assign step_idx  = oaht_pkg::CONST_IDX_W'(oaht_pkg::QUAD_STEP_W - 1)
                       - cnt_reg[oaht_pkg::CONST_IDX_W-1:0];
    assign inc_idx   = oaht_pkg::CONST_IDX_W'(oaht_pkg::QUAD_INC_W - 1)
                       - cnt_reg[oaht_pkg::CONST_IDX_W-1:0];
    assign mul_idx   = BIT_W'(SZ_W - 1) - cnt_reg[BIT_W:1];
    assign key_match = (rd_key == key_reg);

    // operand selection for the shared adder
    always_comb
    begin
        ua   = '0;
        ub   = '0;
        ucin = 1'b0;
        case (state_reg)
            S_KMOD:
            begin
                ua   = r_reg;
                ub   = r_reg;
                ucin = key_reg[KEY_WIDTH-1];
            end
            S_CONST1:
            begin
                ua   = r_reg;
                ub   = r_reg;
                ucin = oaht_pkg::QUAD_STEP[step_idx];
            end
            S_CONST2:
            begin
                ua   = r_reg;
                ub   = r_reg;
                ucin = oaht_pkg::QUAD_INC[inc_idx];
            end
            S_MUL:
            begin
                ua = acc_reg;
                if (!cnt_reg[0])
                begin
                    ub = acc_reg;
                end
                else if (i_reg[mul_idx])
                begin
                    ub = q_reg;
                end
            end
            S_ADDR:
            begin
                ua = lin_reg;
                ub = acc_reg;
            end
            S_ADV_LIN:
            begin
                ua   = lin_reg;
                ucin = 1'b1;
            end
            S_ADV_Q:
            begin
                ua = q_reg;
                ub = d_reg;
            end
            S_ADV_D:
            begin
                ua = d_reg;
                ub = c2_reg;
            end
            default:
            begin
                ua = '0;
            end
        endcase
    end

    // sequencer and next values
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        rsp_valid_next  = rsp_valid_reg & rsp_stall;
        func_next       = func_reg;
        key_next        = key_reg;
        m_next          = m_reg;
        s_next          = s_reg;
        cnt_next        = cnt_reg;
        r_next          = r_reg;
        lin_next        = lin_reg;
        q_next          = q_reg;
        d_next          = d_reg;
        c2_next         = c2_reg;
        acc_next        = acc_reg;
        i_next          = i_reg;
        pos_next        = pos_reg;
        ok_next         = ok_reg;
        slot_index_next = slot_index_reg;
        failed_next     = failed_reg;
        ctl             = '0;
        store_addr      = IW'(pos_reg);

        case (state_reg)
            // clearing pass over the status memory
            S_CLEAR:
            begin
                ctl.st_we   = 1'b1;
                ctl.st_data = oaht_pkg::ST_EMPTY;
                store_addr  = clr_reg;
                if (clr_reg == IW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            // take a request
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next = func;
                    key_next  = key;
                    m_next    = probe_method_reg;
                    s_next    = size_clamped;
                    cnt_next  = '0;
                    r_next    = '0;
                    acc_next  = '0;
                    i_next    = '0;
                    ok_next   = 1'b0;
                    if (size_clamped == '0 || func > oaht_pkg::FUNC_REMOVE)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_KMOD;
                    end
                end
            end

            // key mod size, one key bit a cycle, key rotates back in place
            S_KMOD:
            begin
                r_next   = uy;
                key_next = {key_reg[KEY_WIDTH-2:0], key_reg[KEY_WIDTH-1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KEY_WIDTH - 1))
                begin
                    lin_next = uy;
                    q_next   = uy;
                    cnt_next = '0;
                    r_next   = '0;
                    if (is_quad || is_dbl)
                    begin
                        state_next = S_CONST1;
                    end
                    else
                    begin
                        state_next = S_ADDR;
                    end
                end
            end

            // first difference of the quadratic term mod size
            S_CONST1:
            begin
                r_next   = uy;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(oaht_pkg::QUAD_STEP_W - 1))
                begin
                    d_next     = uy;
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = S_CONST2;
                end
            end

            // second difference of the quadratic term mod size
            S_CONST2:
            begin
                r_next   = uy;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(oaht_pkg::QUAD_INC_W - 1))
                begin
                    c2_next    = uy;
                    state_next = S_ADDR;
                end
            end

            // probe position for this attempt
            S_ADDR:
            begin
                if (is_dbl)
                begin
                    pos_next = uy;
                end
                else if (is_quad)
                begin
                    pos_next = q_reg;
                end
                else
                begin
                    pos_next = lin_reg;
                end
                state_next = S_READ;
            end

            S_READ:
            begin
                ctl.rd     = 1'b1;
                state_next = S_CHECK;
            end

            // decide on the slot just read
            S_CHECK:
            begin
                if (func_reg == oaht_pkg::FUNC_INSERT)
                begin
                    if (rd_status != oaht_pkg::ST_USED)
                    begin
                        ctl.st_we   = 1'b1;
                        ctl.key_we  = 1'b1;
                        ctl.st_data = oaht_pkg::ST_USED;
                        ok_next     = 1'b1;
                        state_next  = S_FINISH;
                    end
                    else if (i_reg == s_reg - 1'b1)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_ADV_LIN;
                    end
                end
                else
                begin
                    if (rd_status == oaht_pkg::ST_USED && key_match)
                    begin
                        if (func_reg == oaht_pkg::FUNC_REMOVE)
                        begin
                            ctl.st_we   = 1'b1;
                            ctl.st_data = oaht_pkg::ST_DELETED;
                        end
                        ok_next    = 1'b1;
                        state_next = S_FINISH;
                    end
                    else if (rd_status == oaht_pkg::ST_EMPTY)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (i_reg == s_reg - 1'b1)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_ADV_LIN;
                    end
                end
            end

            // next attempt: linear term and attempt count
            S_ADV_LIN:
            begin
                lin_next = uy;
                i_next   = i_reg + 1'b1;
                if (is_quad || is_dbl)
                begin
                    state_next = S_ADV_Q;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end

            S_ADV_Q:
            begin
                q_next     = uy;
                state_next = S_ADV_D;
            end

            S_ADV_D:
            begin
                d_next = uy;
                if (is_dbl)
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end

            // i * h2 mod size, double and add, msb of i first
            S_MUL:
            begin
                acc_next = uy;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(2 * SZ_W - 1))
                begin
                    state_next = S_ADDR;
                end
            end

            // post the response once the output register is free
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    slot_index_next = ok_reg ? IW'(pos_reg) : '0;
                    failed_next     = ~ok_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        m_reg          <= m_next;
        s_reg          <= s_next;
        cnt_reg        <= cnt_next;
        r_reg          <= r_next;
        lin_reg        <= lin_next;
        q_reg          <= q_next;
        d_reg          <= d_next;
        c2_reg         <= c2_next;
        acc_reg        <= acc_next;
        i_reg          <= i_next;
        pos_reg        <= pos_next;
        ok_reg         <= ok_next;
        slot_index_reg <= slot_index_next;
        failed_reg     <= failed_next;
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign slot_index = slot_index_reg;
    assign failed     = failed_reg;

endmodule

/* src/oaht_modadd.sv */
// shared modular adder: (a + b + cin) mod size for a, b below size
module oaht_modadd (
    input  logic [oaht_pkg::SZ_W-1:0] a,
    input  logic [oaht_pkg::SZ_W-1:0] b,
    input  logic                      cin,
    input  logic [oaht_pkg::SZ_W-1:0] size,
    output logic [oaht_pkg::SZ_W-1:0] y
);

    logic [oaht_pkg::SZ_W:0] sum;
    logic [oaht_pkg::SZ_W:0] diff;

    // sum stays below twice the size, so one subtract reduces it
    always_comb
    begin
        sum  = {1'b0, a} + {1'b0, b} + {{oaht_pkg::SZ_W{1'b0}}, cin};
        diff = sum - {1'b0, size};
        if (sum >= {1'b0, size})
        begin
            y = diff[oaht_pkg::SZ_W-1:0];
        end
        else
        begin
            y = sum[oaht_pkg::SZ_W-1:0];
        end
    end

endmodule

/* src/oaht_store.sv */
// slot status and key memories, one access per cycle, registered read
module oaht_store #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                              clk,
    input  oaht_pkg::store_ctl_t              ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    addr,
    input  logic [KEY_WIDTH-1:0]              wkey,
    output logic [oaht_pkg::ST_W-1:0]         rd_status,
    output logic [KEY_WIDTH-1:0]              rd_key
);

    logic [oaht_pkg::ST_W-1:0] status_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]      key_mem    [TABLE_DEPTH];

    // status array
    always_ff @(posedge clk)
    begin
        if (ctl.st_we)
        begin
            status_mem[addr] <= ctl.st_data;
        end
        if (ctl.rd)
        begin
            rd_status <= status_mem[addr];
        end
    end

    // key array
    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[addr] <= wkey;
        end
        if (ctl.rd)
        begin
            rd_key <= key_mem[addr];
        end
    end

endmodule

/* src/oaht_checker.sv */
// port-level checks of the hash table and their binding to the top level
`include "open_addressing_hash_table_assert.svh"

module oaht_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_stall,
    input logic                            rsp_valid,
    input logic                            rsp_stall,
    input logic [$clog2(TABLE_DEPTH)-1:0]  slot_index,
    input logic                            failed
);

    // a stalled response keeps its contents
    `OAHT_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(slot_index) && $stable(failed), "stalled response changed")

    // a failed request reports slot zero
    `OAHT_ASSERT_IMP(a_fail_zero, rsp_valid && failed, slot_index == '0, "failed response with nonzero slot")

    // the block is busy right after it takes a request
    `OAHT_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall, "request taken while still accepting")

    // a new response only comes out of a busy cycle
    `OAHT_ASSERT_IMP(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall), "response without request in flight")

endmodule

bind open_addressing_hash_table oaht_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_oaht_checker (.*);

/* dv/tb_open_addressing_hash_table.sv */
// self-checking testbench for the open-addressed hash table: directed cases, then random traffic
module tb_open_addressing_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // codes with no name in the package
    localparam logic [oaht_pkg::FUNC_W-1:0]   FUNC_UNKNOWN = 2'd3;
    localparam logic [oaht_pkg::METHOD_W-1:0] METHOD_SPARE = 2'd3;

    // quadratic probe coefficients
    localparam longint unsigned QUAD_LIN_COEF = 183;
    localparam longint unsigned QUAD_SQ_COEF  = 8192;

    localparam int     RANDOM_REQUESTS = 1700;
    localparam int     SETTLE_CYCLES   = 200;
    localparam longint CYCLE_LIMIT     = 40_000_000;

    typedef struct packed {
        logic [IDX_W-1:0] slot_index;
        logic             failed;
    } lookup_result_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [oaht_pkg::APB_ADDR_W-1:0] paddr;
    logic [oaht_pkg::APB_DATA_W-1:0] pwdata;
    logic [oaht_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            req_valid;
    logic                            req_stall;
    logic [oaht_pkg::FUNC_W-1:0]     func;
    logic [KEY_WIDTH-1:0]            key;
    logic                            rsp_valid;
    logic                            rsp_stall;
    logic [IDX_W-1:0]                slot_index;
    logic                            failed;

    // shadow of the table and its registers
    logic [oaht_pkg::ST_W-1:0]     slot_state [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]          slot_key   [TABLE_DEPTH];
    logic [oaht_pkg::METHOD_W-1:0] cur_method;
    logic [oaht_pkg::SZ_W-1:0]     cur_size;

    lookup_result_t expected_lookups [$];
    int             mismatch_count = 0;
    int             burst_left     = 0;
    longint         cycle_count    = 0;

    open_addressing_hash_table u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .func       (func),
        .key        (key),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .slot_index (slot_index),
        .failed     (failed)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // effective probe modulus, clamped to the depth
    function automatic int unsigned probe_modulus();
        return (cur_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_size);
    endfunction

    // slot probed at attempt i, all terms reduced modulo s
    function automatic longint unsigned probe_slot(input longint unsigned kmod,
                                                   input longint unsigned i,
                                                   input longint unsigned s);
        longint unsigned lin;
        longint unsigned quad;
        lin  = (kmod + i % s) % s;
        quad = (kmod + (QUAD_LIN_COEF * i) % s + (QUAD_SQ_COEF * ((i * i) % s)) % s) % s;
        case (cur_method)
            oaht_pkg::METHOD_QUAD:   return quad;
            oaht_pkg::METHOD_DOUBLE: return (lin + ((i % s) * quad) % s) % s;
            default:                 return lin;
        endcase
    endfunction

    // walk the probe sequence, update the shadow table and give the slot found or taken
    function automatic lookup_result_t lookup_slot(input logic [oaht_pkg::FUNC_W-1:0] f,
                                                   input logic [KEY_WIDTH-1:0] k);
        lookup_result_t  res;
        longint unsigned s;
        longint unsigned kmod;
        longint unsigned p;
        longint unsigned i;
        res.slot_index = '0;
        res.failed     = 1'b1;
        s = probe_modulus();
        if (s == 0 || f == FUNC_UNKNOWN)
            return res;
        kmod = k % s;
        for (i = 0; i < s; i++)
        begin
            p = probe_slot(kmod, i, s);
            if (f == oaht_pkg::FUNC_INSERT)
            begin
                if (slot_state[p] != oaht_pkg::ST_USED)
                begin
                    slot_key[p]    = k;
                    slot_state[p]  = oaht_pkg::ST_USED;
                    res.slot_index = p[IDX_W-1:0];
                    res.failed     = 1'b0;
                    break;
                end
            end
            else if (slot_state[p] == oaht_pkg::ST_USED)
            begin
                if (slot_key[p] == k)
                begin
                    if (f == oaht_pkg::FUNC_REMOVE)
                        slot_state[p] = oaht_pkg::ST_DELETED;
                    res.slot_index = p[IDX_W-1:0];
                    res.failed     = 1'b0;
                    break;
                end
            end
            else if (slot_state[p] == oaht_pkg::ST_EMPTY)
            begin
                break;
            end
        end
        return res;
    endfunction

    // key of a random slot in the probed range with the given status, else the fallback
    function automatic logic [KEY_WIDTH-1:0] stored_key(
        input logic [oaht_pkg::ST_W-1:0] want_state,
        input logic [KEY_WIDTH-1:0]      fallback);
        int hits [$];
        int s;
        int i;
        s = probe_modulus();
        for (i = 0; i < s; i++)
            if (slot_state[i] == want_state)
                hits.push_back(i);
        if (hits.size() == 0)
            return fallback;
        return slot_key[hits[$urandom_range(0, hits.size() - 1)]];
    endfunction

    // one request: bursts with random gaps, held until the block takes it
    task automatic send_request(input logic [oaht_pkg::FUNC_W-1:0] f,
                                input logic [KEY_WIDTH-1:0] k);
        int gap;
        int roll;
        @(negedge clk);
        if (burst_left == 0)
        begin
            roll = $urandom_range(0, 3);
            if (roll == 0)
                gap = 0;
            else if (roll == 3)
                gap = $urandom_range(20, 90);
            else
                gap = $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_valid <= 1'b1;
        func      <= f;
        key       <= k;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_lookups.push_back(lookup_slot(f, k));
    endtask

    // drop valid and wait for every outstanding response
    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
    endtask

    // one apb transfer: setup cycle, then access cycle until pready
    task automatic apb_transfer(input logic wr, input logic reg_idx,
                                input logic [oaht_pkg::APB_DATA_W-1:0] wdata,
                                output logic [oaht_pkg::APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= oaht_pkg::APB_ADDR_W'({reg_idx, 2'b00});
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
    endtask

    // read a register back and compare with the shadow copy
    task automatic read_register(input logic reg_idx);
        logic [oaht_pkg::APB_DATA_W-1:0] rdata;
        logic [oaht_pkg::APB_DATA_W-1:0] want;
        apb_transfer(1'b0, reg_idx, '0, rdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        want = (reg_idx == oaht_pkg::REG_TABLE_SIZE) ?
               oaht_pkg::APB_DATA_W'(cur_size) : oaht_pkg::APB_DATA_W'(cur_method);
        if (rdata !== want)
        begin
            $error("%s: expected %0d, got %0d",
                   (reg_idx == oaht_pkg::REG_TABLE_SIZE) ? "table_size" : "probe_method",
                   want, rdata);
            mismatch_count++;
        end
    endtask

    task automatic set_register(input logic reg_idx,
                                input logic [oaht_pkg::APB_DATA_W-1:0] value);
        logic [oaht_pkg::APB_DATA_W-1:0] unused_rdata;
        apb_transfer(1'b1, reg_idx, value, unused_rdata);
        if (reg_idx == oaht_pkg::REG_TABLE_SIZE)
            cur_size = value[oaht_pkg::SZ_W-1:0];
        else
            cur_method = value[oaht_pkg::METHOD_W-1:0];
        read_register(reg_idx);
    endtask

    task automatic configure(input logic [oaht_pkg::METHOD_W-1:0] m,
                             input logic [oaht_pkg::SZ_W-1:0] sz);
        set_register(oaht_pkg::REG_PROBE_METHOD, oaht_pkg::APB_DATA_W'(m));
        set_register(oaht_pkg::REG_TABLE_SIZE, oaht_pkg::APB_DATA_W'(sz));
    endtask

    // registers come out of reset as linear over the full depth
    task automatic test_register_reset();
        read_register(oaht_pkg::REG_PROBE_METHOD);
        read_register(oaht_pkg::REG_TABLE_SIZE);
    endtask

    // misses on the empty table, key extremes, a collision, deleted slot skipping
    task automatic test_empty_table_defaults();
        send_request(oaht_pkg::FUNC_SEARCH, 32'h1234_5678);
        send_request(oaht_pkg::FUNC_REMOVE, 32'h0000_0000);
        send_request(oaht_pkg::FUNC_INSERT, 32'h0000_0000);
        send_request(oaht_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
        send_request(oaht_pkg::FUNC_INSERT, 32'h0000_0400);
        send_request(oaht_pkg::FUNC_SEARCH, 32'hFFFF_FFFF);
        send_request(oaht_pkg::FUNC_REMOVE, 32'h0000_0000);
        send_request(oaht_pkg::FUNC_SEARCH, 32'h0000_0400);
        send_request(FUNC_UNKNOWN, 32'h0000_0400);
        wait_idle();
    endtask

    // one slot: take, full, miss, remove, skip deleted, reuse deleted
    task automatic test_single_slot();
        configure(oaht_pkg::METHOD_LINEAR, 11'd1);
        send_request(oaht_pkg::FUNC_INSERT, 32'd5);
        send_request(oaht_pkg::FUNC_INSERT, 32'd7);
        send_request(oaht_pkg::FUNC_SEARCH, 32'd7);
        send_request(oaht_pkg::FUNC_REMOVE, 32'd5);
        send_request(oaht_pkg::FUNC_SEARCH, 32'd5);
        send_request(oaht_pkg::FUNC_INSERT, 32'd7);
        wait_idle();
    endtask

    // size zero probes nothing
    task automatic test_zero_size();
        configure(oaht_pkg::METHOD_QUAD, 11'd0);
        send_request(oaht_pkg::FUNC_INSERT, 32'd1);
        send_request(oaht_pkg::FUNC_SEARCH, 32'd7);
        send_request(oaht_pkg::FUNC_REMOVE, 32'd7);
        wait_idle();
    endtask

    // oversize table clamps to the depth, spare method probes as linear
    task automatic test_clamped_size_spare_method();
        configure(METHOD_SPARE, 11'd2047);
        send_request(oaht_pkg::FUNC_INSERT, 32'hFFFF_FC01);
        send_request(oaht_pkg::FUNC_SEARCH, 32'hFFFF_FC01);
        wait_idle();
    endtask

    // keys sharing a home slot under the double form
    task automatic test_double_form_collisions();
        configure(oaht_pkg::METHOD_DOUBLE, 11'd7);
        send_request(oaht_pkg::FUNC_INSERT, 32'd14);
        send_request(oaht_pkg::FUNC_INSERT, 32'd21);
        send_request(oaht_pkg::FUNC_INSERT, 32'd28);
        send_request(oaht_pkg::FUNC_INSERT, 32'd35);
        send_request(oaht_pkg::FUNC_REMOVE, 32'd21);
        send_request(oaht_pkg::FUNC_SEARCH, 32'd28);
        wait_idle();
    endtask

    // mostly stored keys for lookups, fresh keys for inserts, a little noise
    task automatic send_random_request();
        logic [oaht_pkg::FUNC_W-1:0] f;
        logic [KEY_WIDTH-1:0]        k;
        int                          roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            f = oaht_pkg::FUNC_INSERT;
        else if (roll < 68)
            f = oaht_pkg::FUNC_SEARCH;
        else if (roll < 95)
            f = oaht_pkg::FUNC_REMOVE;
        else
            f = FUNC_UNKNOWN;
        k = $urandom();
        if (f == oaht_pkg::FUNC_INSERT)
        begin
            if ($urandom_range(0, 5) == 0)
                k = stored_key(oaht_pkg::ST_USED, k);
        end
        else if ($urandom_range(0, 3) != 0)
        begin
            k = stored_key(oaht_pkg::ST_USED, k);
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            k = stored_key(oaht_pkg::ST_DELETED, k);
        end
        send_request(f, k);
    endtask

    // rounds of random requests, each under a fresh setting; small tables mostly
    task automatic test_random_traffic();
        int                            sent;
        int                            round_len;
        int                            roll;
        logic [oaht_pkg::METHOD_W-1:0] m;
        logic [oaht_pkg::SZ_W-1:0]     sz;
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            wait_idle();
            m = ($urandom_range(0, 9) == 0) ?
                METHOD_SPARE : oaht_pkg::METHOD_W'($urandom_range(0, 2));
            roll = $urandom_range(0, 99);
            if (roll < 2)
                sz = '0;
            else if (roll < 5)
                sz = oaht_pkg::SIZE_RESET;
            else if (roll < 8)
                sz = oaht_pkg::SZ_W'($urandom_range(1025, 2047));
            else if (roll < 22)
                sz = oaht_pkg::SZ_W'($urandom_range(17, 48));
            else
                sz = oaht_pkg::SZ_W'($urandom_range(1, 16));
            configure(m, sz);
            round_len = (sz >= oaht_pkg::SIZE_RESET) ? 24 : $urandom_range(30, 70);
            repeat (round_len)
                send_random_request();
            sent += round_len;
        end
        wait_idle();
    endtask

    // response stall in changing patterns, including stretches with none
    initial
    begin : rsp_stall_pattern
        stall_mode_t mode;
        int          hold;
        rsp_stall = 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            hold = $urandom_range(20, 300);
            repeat (hold)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:     rsp_stall <= 1'b0;
                    STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
                    default:        rsp_stall <= ((cycle_count % 7) < 3);
                endcase
            end
        end
    end

    // compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin : check_lookup
        lookup_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_lookups.size() == 0)
            begin
                $error("response with no request outstanding: slot_index %0d, failed %0b",
                       slot_index, failed);
                mismatch_count++;
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (slot_index !== want.slot_index)
                begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index, slot_index);
                    mismatch_count++;
                end
                if (failed !== want.failed)
                begin
                    $error("failed: expected %0b, got %0b", want.failed, failed);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int i;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        func      = oaht_pkg::FUNC_INSERT;
        key       = '0;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_state[i] = oaht_pkg::ST_EMPTY;
            slot_key[i]   = '0;
        end
        cur_method = oaht_pkg::METHOD_LINEAR;
        cur_size   = oaht_pkg::SIZE_RESET;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_register_reset();
        test_empty_table_defaults();
        test_single_slot();
        test_zero_size();
        test_clamped_size_spare_method();
        test_double_form_collisions();
        test_random_traffic();

        // catch any stray response
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/oaht_pkg.sv
src/oaht_modadd.sv
src/oaht_store.sv
src/open_addressing_hash_table.sv
src/oaht_checker.sv
dv/tb_open_addressing_hash_table.sv
